// File: rtl/lir_pkg.sv
// shared types and constants for the linear interpolation resampler
package lir_pkg;

    // fixed field widths
    localparam int SAMPLE_W  = 8;
    localparam int CFG_W     = 21;
    localparam int POS_W     = 32;
    localparam int FRAC_W    = 16;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    // register reset values
    localparam logic [CFG_W-1:0] PHASE_STEP_RESET   = 21'd65536;
    localparam logic [CFG_W-1:0] OUTPUT_COUNT_RESET = 21'd1;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // register index codes
    typedef enum logic {
        REG_PHASE_STEP   = 1'b0,
        REG_OUTPUT_COUNT = 1'b1
    } t_reg_idx;

    // queue status seen by producer and consumer
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage

// File: rtl/linear_interp_resampler.sv
// an output word passes through the pair queue and then the output register after its source word is taken
// throughput: one output word per cycle while the output is not stalled and a pair is queued; the back end
// retires each pair in a separate step after its last output word
// the front end takes one source word per cycle while the four-entry pair queue has room
// reset (synchronous, active low) clears queue, position, counts and output valid;
// phase_step returns to 65536 and output_count to 1
module linear_interp_resampler
    import lir_pkg::*;
#(
    parameter int MAX_SOURCE_LENGTH = 65536,
    parameter int MAX_UPSAMPLE      = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    output logic                       o_last_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_AW-1:0]          paddr,
    input  logic [APB_DW-1:0]          pwdata,
    output logic [APB_DW-1:0]          prdata,
    output logic                       pready
);

    localparam int IW  = $clog2(MAX_SOURCE_LENGTH + 1);
    localparam int LW  = ($clog2(MAX_SOURCE_LENGTH) > 0) ? $clog2(MAX_SOURCE_LENGTH) : 1;
    localparam int UPW = $clog2(MAX_UPSAMPLE + 1);
    localparam int PW  = 2*SAMPLE_W + LW;

    logic [CFG_W-1:0] r_phase_step;
    logic [CFG_W-1:0] r_output_count;
    logic             cfg_wr;
    t_reg_idx         cfg_idx;

    t_q_flags         q_flags;
    logic             push;
    logic [PW-1:0]    push_data;
    logic             pop;
    logic [PW-1:0]    head;

    // register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step   <= PHASE_STEP_RESET;
            r_output_count <= OUTPUT_COUNT_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_PHASE_STEP:   r_phase_step   <= pwdata[CFG_W-1:0];
                REG_OUTPUT_COUNT: r_output_count <= pwdata[CFG_W-1:0];
                default:          r_phase_step   <= r_phase_step;
            endcase
        end
    end

    // read-back mux
    always_comb begin
        unique case (cfg_idx)
            REG_PHASE_STEP:   prdata = APB_DW'(r_phase_step);
            REG_OUTPUT_COUNT: prdata = APB_DW'(r_output_count);
            default:          prdata = '0;
        endcase
    end

    lir_front #(
        .MAX_SOURCE_LENGTH (MAX_SOURCE_LENGTH),
        .IW                (IW),
        .LW                (LW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_sample_in (i_sample_in),
        .o_in_stall  (o_in_stall),
        .i_q_flags   (q_flags),
        .o_push      (push),
        .o_push_data (push_data)
    );

    lir_queue #(
        .W (PW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_flags     (q_flags)
    );

    lir_back #(
        .MAX_UPSAMPLE (MAX_UPSAMPLE),
        .LW           (LW),
        .UPW          (UPW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_phase_step   (r_phase_step),
        .i_output_count (r_output_count),
        .i_head         (head),
        .i_q_flags      (q_flags),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sample_out   (o_sample_out),
        .o_last_out     (o_last_out)
    );

endmodule

// File: rtl/lir_front.sv
// front end: takes source words, keeps previous sample and index, queues sample pairs
module lir_front
    import lir_pkg::*;
#(
    parameter int MAX_SOURCE_LENGTH = 65536,
    parameter int IW = 17,
    parameter int LW = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    output logic                       o_in_stall,
    input  t_q_flags                   i_q_flags,
    output logic                       o_push,
    output logic [2*SAMPLE_W+LW-1:0]   o_push_data
);

    logic signed [SAMPLE_W-1:0] r_prev;
    logic [IW-1:0]              r_index;
    logic                       accept;
    logic [IW-1:0]              left_full;

    // accept whenever the queue has room
    assign o_in_stall = i_q_flags.full;
    assign accept     = i_in_valid && !i_q_flags.full;

    // pair is queued from the second sample on
    assign left_full   = r_index - IW'(1);
    assign o_push      = accept && (r_index != '0);
    assign o_push_data = {r_prev, i_sample_in, left_full[LW-1:0]};

    // previous sample and saturating index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_index <= '0;
        end else if (accept) begin
            r_prev <= i_sample_in;
            if (r_index < IW'(MAX_SOURCE_LENGTH)) begin
                r_index <= r_index + IW'(1);
            end
        end
    end

endmodule

// File: rtl/lir_queue.sv
// short queue of sample pairs between front and back
module lir_queue
    import lir_pkg::*;
#(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_push_data,
    input  logic         i_pop,
    output logic [W-1:0] o_head,
    output t_q_flags     o_flags
);

    logic [W-1:0]  r_store [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_fill;
    logic            do_push;
    logic            do_pop;

    assign o_flags.full  = (r_fill == (Q_AW+1)'(Q_DEPTH));
    assign o_flags.empty = (r_fill == '0);
    assign do_push       = i_push && !o_flags.full;
    assign do_pop        = i_pop && !o_flags.empty;
    assign o_head        = r_store[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_store[r_wr] <= i_push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_fill <= r_fill + (Q_AW+1)'(1);
                2'b01:   r_fill <= r_fill - (Q_AW+1)'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

// File: rtl/lir_back.sv
// back end: walks the position over each queued pair, one output word per cycle unless stalled, empty or popping
module lir_back
    import lir_pkg::*;
#(
    parameter int MAX_UPSAMPLE = 16,
    parameter int LW  = 16,
    parameter int UPW = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [CFG_W-1:0]           i_phase_step,
    input  logic [CFG_W-1:0]           i_output_count,
    input  logic [2*SAMPLE_W+LW-1:0]   i_head,
    input  t_q_flags                   i_q_flags,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    output logic                       o_last_out
);

    localparam int CW    = (LW > FRAC_W) ? LW : FRAC_W;
    localparam int NUM_W = 26;

    // ((1-f)*a + f*b)/2 with truncation toward zero
    function automatic logic signed [SAMPLE_W-1:0] interp(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b,
        input logic [FRAC_W-1:0]          f
    );
        logic signed [SAMPLE_W:0]   diff;
        logic signed [NUM_W-1:0]    prod;
        logic signed [NUM_W-1:0]    num;
        logic signed [NUM_W-1:0]    adj;
        logic signed [NUM_W-1:0]    res;
        diff = (SAMPLE_W+1)'(b) - (SAMPLE_W+1)'(a);
        prod = NUM_W'($signed({1'b0, f})) * NUM_W'(diff);
        num  = NUM_W'($signed({a, {FRAC_W{1'b0}}})) + prod;
        adj  = num[NUM_W-1] ? (num + NUM_W'(131071)) : num;
        res  = adj >>> (FRAC_W + 1);
        return res[SAMPLE_W-1:0];
    endfunction

    logic [POS_W-1:0]           r_pos;
    logic [CFG_W-1:0]           r_done;
    logic [UPW-1:0]             r_cnt;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_out_last;

    logic signed [SAMPLE_W-1:0] head_prev;
    logic signed [SAMPLE_W-1:0] head_cur;
    logic [LW-1:0]              head_left;
    logic                       out_free;
    logic                       more;
    logic                       emit;
    logic [CFG_W-1:0]           done_inc;

    assign head_prev = i_head[2*SAMPLE_W+LW-1 -: SAMPLE_W];
    assign head_cur  = i_head[SAMPLE_W+LW-1 -: SAMPLE_W];
    assign head_left = i_head[LW-1:0];

    // another output due from the pair at the head
    assign more = (r_cnt < UPW'(MAX_UPSAMPLE))
               && (r_done < i_output_count)
               && (CW'(r_pos[POS_W-1:FRAC_W]) <= CW'(head_left));

    assign out_free = !r_out_valid || !i_out_stall;
    assign emit     = !i_q_flags.empty && more && out_free;
    assign o_pop    = !i_q_flags.empty && !more;
    assign done_inc = r_done + CFG_W'(1);

    // position, output count and per-pair count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_done <= '0;
            r_cnt  <= '0;
        end else if (o_pop) begin
            r_cnt <= '0;
        end else if (emit) begin
            r_pos  <= r_pos + POS_W'(i_phase_step);
            r_done <= done_inc;
            r_cnt  <= r_cnt + UPW'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_sample <= interp(head_prev, head_cur, r_pos[FRAC_W-1:0]);
            r_out_last   <= (done_inc == i_output_count);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_last_out   = r_out_last;

endmodule

// File: rtl/lir_checker.sv
// port-level checks for the resampler, bound to the top level
module lir_checker
    import lir_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [SAMPLE_W-1:0] o_sample_out,
    input logic                o_last_out
);

    // a stalled output word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    // a stalled output word keeps its contents
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_sample_out) && $stable(o_last_out))
        else $error("output word changed while stalled");

    // halving keeps every output within -64..63
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample_out[SAMPLE_W-1] == o_sample_out[SAMPLE_W-2]))
        else $error("output sample outside halved range");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_sample_out (o_sample_out),
    .o_last_out   (o_last_out)
);
